FILE: hdl/iir_df1_pkg.sv
// Shared constants, types and helpers of the direct form I IIR filter.
package iir_df1_pkg;

  localparam int MAX_TAPS       = 16;
  localparam int SAMPLE_BITS    = 16;
  localparam int COEF_BITS      = 24;
  localparam int COEF_FRAC_BITS = 19;

  localparam int TAP_CNT_BITS   = 5;
  localparam int REQ_BITS       = 2;
  localparam int COEF_IDX_BITS  = 4;
  localparam int TAP_CNT_RESET  = 3;

  localparam int TAP_W   = $clog2(MAX_TAPS);
  localparam int CNT_W   = $clog2(MAX_TAPS + 1);
  localparam int ADDR_W  = TAP_W + 1;
  localparam int MEM_DEPTH = 2 * MAX_TAPS;
  localparam int PROD_W  = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W   = PROD_W + CNT_W + 1;
  localparam int SHIFT_W = ACC_W - COEF_FRAC_BITS;

  typedef enum logic [REQ_BITS-1:0] {
    REQ_SAMPLE   = 2'd0,
    REQ_FWD_COEF = 2'd1,
    REQ_FBK_COEF = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FWD,
    ST_FBK,
    ST_DRAIN
  } state_t;

  // Taps in use: the register value clamped to the supported range.
  function automatic logic [CNT_W-1:0] taps_in_use(input logic [TAP_CNT_BITS-1:0] tap_count);
    logic [CNT_W-1:0] res;
    if (int'(tap_count) < 2) begin
      res = CNT_W'(2);
    end else if (int'(tap_count) > MAX_TAPS) begin
      res = CNT_W'(MAX_TAPS);
    end else begin
      res = CNT_W'(tap_count);
    end
    return res;
  endfunction

endpackage

FILE: hdl/iir_df1_in_if.sv
// Input channel of the IIR filter: sample and coefficient-write transactions.
interface iir_df1_in_if
  import iir_df1_pkg::*;
;
  logic                            valid;
  logic                            ready;
  logic [REQ_BITS-1:0]             req_type;
  logic [COEF_IDX_BITS-1:0]        coef_index;
  logic signed [COEF_BITS-1:0]     coef_value;
  logic signed [SAMPLE_BITS-1:0]   sample_in;

  modport source (output valid, req_type, coef_index, coef_value, sample_in, input ready);
  modport sink   (input valid, req_type, coef_index, coef_value, sample_in, output ready);
endinterface

FILE: hdl/iir_df1_out_if.sv
// Result channel of the IIR filter: filtered samples with a clip flag.
interface iir_df1_out_if
  import iir_df1_pkg::*;
;
  logic                            valid;
  logic                            ready;
  logic signed [SAMPLE_BITS-1:0]   sample_out;
  logic                            saturated;

  modport source (output valid, sample_out, saturated, input ready);
  modport sink   (input valid, sample_out, saturated, output ready);
endinterface

FILE: hdl/iir_direct_form_one_filter.sv
// Top level of the direct form I IIR filter with memory-held state.
//
//   channel   | direction | transaction
//   ----------+-----------+-------------------------------------------------
//   in_chan   | sink      | one sample to filter or one coefficient to load
//   out_chan  | source    | one filtered, saturated sample per input sample
//   cfg_*     | write     | tap count L (2..MAX_TAPS), restarts the filter
//
// A coefficient transaction is taken in the idle state. A sample transaction stores the input,
// streams the 2L-1 products through the single multiply-accumulate, then drains the read and
// multiply stages and writes y back to the output history once the output register is free.
// Reset (synchronous, rst_n low) and any tap count write clear the history valid bits and
// ring positions at once; reset also clears coefficient valid bits. A finished result waits
// in the output register while the next input is taken; while it stays full, a new result waits in drain.
module iir_direct_form_one_filter
  import iir_df1_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  iir_df1_in_if.sink               in_chan,
  iir_df1_out_if.source            out_chan,
  input  logic                     cfg_we,
  input  logic [TAP_CNT_BITS-1:0]  cfg_wdata
);

  // Both memories are split in two halves: the lower half holds the input
  // history and b coefficients, the upper half the output history and a.
  logic [SAMPLE_BITS-1:0] hist_mem [MEM_DEPTH];
  logic [COEF_BITS-1:0]   coef_mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0]   hist_vld_r;
  logic [MEM_DEPTH-1:0]   coef_vld_r;

  state_t state_r, state_nxt;

  logic [TAP_CNT_BITS-1:0] tap_count_r;
  logic [TAP_W-1:0]        in_pos_r, in_pos_nxt;
  logic [TAP_W-1:0]        out_pos_r, out_pos_nxt;
  logic [TAP_W-1:0]        xp_r, xp_nxt;
  logic [TAP_W-1:0]        yp_r, yp_nxt;
  logic [TAP_W-1:0]        k_r, k_nxt;

  logic [CNT_W-1:0]        taps;
  logic [TAP_W-1:0]        lm1, lm2;
  logic [TAP_W-1:0]        in_pos_eff, out_pos_eff;

  // Read and multiply pipeline.
  logic                    issue;
  logic                    issue_neg;
  logic [ADDR_W-1:0]       hist_raddr, coef_raddr;
  logic [SAMPLE_BITS-1:0]  hist_q_r;
  logic [COEF_BITS-1:0]    coef_q_r;
  logic                    hist_ok_r, coef_ok_r;
  logic                    rd_vld_r, rd_neg_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                    prod_vld_r, prod_neg_r;
  logic signed [ACC_W-1:0] acc_r;

  // Memory write controls.
  logic                    hist_we;
  logic [ADDR_W-1:0]       hist_waddr;
  logic [SAMPLE_BITS-1:0]  hist_wdata;
  logic                    coef_we;
  logic [ADDR_W-1:0]       coef_waddr;

  logic                    in_fire, sample_fire, finish;
  logic                    out_free;

  // Rounding and saturation of the accumulator.
  logic signed [ACC_W-1:0]   acc_rnd;
  logic signed [SHIFT_W-1:0] acc_sh;
  logic [SHIFT_W-SAMPLE_BITS:0] acc_top;
  logic                      ovf;
  logic [SAMPLE_BITS-1:0]    y_val;

  logic                    out_vld_r;
  logic [SAMPLE_BITS-1:0]  out_sample_r;
  logic                    out_sat_r;

  assign taps = taps_in_use(tap_count_r);
  assign lm1  = TAP_W'(taps - CNT_W'(1));
  assign lm2  = TAP_W'(taps - CNT_W'(2));

  // Positions are always inside the ring; the checks mirror the restart rule.
  assign in_pos_eff  = (CNT_W'(in_pos_r) >= taps) ? '0 : in_pos_r;
  assign out_pos_eff = (CNT_W'(out_pos_r) >= (taps - CNT_W'(1))) ? '0 : out_pos_r;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign sample_fire   = in_fire && (in_chan.req_type == REQ_SAMPLE);

  assign out_free = !out_vld_r || out_chan.ready;
  assign finish   = (state_r == ST_DRAIN) && !rd_vld_r && !prod_vld_r && out_free;

  // Round to nearest with ties upward, then clip to the sample range.
  assign acc_rnd = acc_r + (ACC_W'(1) <<< (COEF_FRAC_BITS - 1));
  assign acc_sh  = SHIFT_W'(acc_rnd >>> COEF_FRAC_BITS);
  assign acc_top = acc_sh[SHIFT_W-1:SAMPLE_BITS-1];
  assign ovf     = !((&acc_top) || !(|acc_top));
  always_comb begin
    if (!ovf) begin
      y_val = acc_sh[SAMPLE_BITS-1:0];
    end else if (acc_sh[SHIFT_W-1]) begin
      y_val = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      y_val = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  // Sequencer: next state, read addresses and ring pointers.
  always_comb begin
    state_nxt   = state_r;
    xp_nxt      = xp_r;
    yp_nxt      = yp_r;
    k_nxt       = k_r;
    in_pos_nxt  = in_pos_r;
    out_pos_nxt = out_pos_r;
    issue       = 1'b0;
    issue_neg   = 1'b0;
    hist_raddr  = {1'b0, xp_r};
    coef_raddr  = {1'b0, k_r};
    unique case (state_r)
      ST_IDLE: begin
        if (sample_fire) begin
          in_pos_nxt = (in_pos_eff == lm1) ? '0 : in_pos_eff + TAP_W'(1);
          out_pos_nxt = out_pos_eff;
          xp_nxt     = in_pos_eff;
          yp_nxt     = (out_pos_eff == '0) ? lm2 : out_pos_eff - TAP_W'(1);
          k_nxt      = '0;
          state_nxt  = ST_FWD;
        end
      end
      ST_FWD: begin
        issue      = 1'b1;
        hist_raddr = {1'b0, xp_r};
        coef_raddr = {1'b0, k_r};
        xp_nxt     = (xp_r == '0) ? lm1 : xp_r - TAP_W'(1);
        if (k_r == lm1) begin
          k_nxt     = TAP_W'(1);
          state_nxt = ST_FBK;
        end else begin
          k_nxt = k_r + TAP_W'(1);
        end
      end
      ST_FBK: begin
        issue      = 1'b1;
        issue_neg  = 1'b1;
        hist_raddr = {1'b1, yp_r};
        coef_raddr = {1'b1, k_r};
        yp_nxt     = (yp_r == '0) ? lm2 : yp_r - TAP_W'(1);
        if (k_r == lm1) begin
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r + TAP_W'(1);
        end
      end
      ST_DRAIN: begin
        if (finish) begin
          out_pos_nxt = (out_pos_r == lm2) ? '0 : out_pos_r + TAP_W'(1);
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // History writes: the new input on acceptance, the result on completion.
  always_comb begin
    hist_we    = 1'b0;
    hist_waddr = {1'b0, in_pos_eff};
    hist_wdata = in_chan.sample_in;
    if (sample_fire) begin
      hist_we = 1'b1;
    end else if (finish) begin
      hist_we    = 1'b1;
      hist_waddr = {1'b1, out_pos_r};
      hist_wdata = y_val;
    end
  end

  assign coef_we = in_fire && (int'(in_chan.coef_index) < MAX_TAPS) &&
                   ((in_chan.req_type == REQ_FWD_COEF) ||
                    (in_chan.req_type == REQ_FBK_COEF));
  assign coef_waddr = {(in_chan.req_type == REQ_FBK_COEF), TAP_W'(in_chan.coef_index)};

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    hist_q_r <= hist_mem[hist_raddr];
  end

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= in_chan.coef_value;
    end
    coef_q_r <= coef_mem[coef_raddr];
  end

  // Control registers, valid bits and the multiply-accumulate pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tap_count_r <= TAP_CNT_BITS'(TAP_CNT_RESET);
      in_pos_r    <= '0;
      out_pos_r   <= '0;
      xp_r        <= '0;
      yp_r        <= '0;
      k_r         <= '0;
      hist_vld_r  <= '0;
      coef_vld_r  <= '0;
      hist_ok_r   <= 1'b0;
      coef_ok_r   <= 1'b0;
      rd_vld_r    <= 1'b0;
      rd_neg_r    <= 1'b0;
      prod_vld_r  <= 1'b0;
      prod_neg_r  <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      xp_r       <= xp_nxt;
      yp_r       <= yp_nxt;
      k_r        <= k_nxt;
      hist_ok_r  <= hist_vld_r[hist_raddr];
      coef_ok_r  <= coef_vld_r[coef_raddr];
      rd_vld_r   <= issue;
      rd_neg_r   <= issue_neg;
      prod_vld_r <= rd_vld_r;
      prod_neg_r <= rd_neg_r;
      if (coef_we) begin
        coef_vld_r[coef_waddr] <= 1'b1;
      end
      if (cfg_we) begin
        // A new tap count restarts the filter with empty histories.
        tap_count_r <= cfg_wdata;
        in_pos_r    <= '0;
        out_pos_r   <= '0;
        hist_vld_r  <= '0;
      end else begin
        in_pos_r  <= in_pos_nxt;
        out_pos_r <= out_pos_nxt;
        if (hist_we) begin
          hist_vld_r[hist_waddr] <= 1'b1;
        end
      end
      if (finish) begin
        out_vld_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= $signed(hist_ok_r ? hist_q_r : '0) * $signed(coef_ok_r ? coef_q_r : '0);
    if (sample_fire) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      if (prod_neg_r) begin
        acc_r <= acc_r - ACC_W'(prod_r);
      end else begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
    end
    if (finish) begin
      out_sample_r <= y_val;
      out_sat_r    <= ovf;
    end
  end

  assign out_chan.valid      = out_vld_r;
  assign out_chan.sample_out = out_sample_r;
  assign out_chan.saturated  = out_sat_r;

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench of the direct form I IIR filter with a filter predictor.
`timescale 1ns / 1ps

import iir_df1_pkg::*;

// One predicted output transaction of the filter.
typedef struct {
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          saturated;
} filt_result_t;

// Tracks the filter state from accepted requests and checks each output.
class iir_output_checker;
  logic [TAP_CNT_BITS-1:0]       tap_reg;
  logic signed [SAMPLE_BITS-1:0] x_hist [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] y_hist [MAX_TAPS];
  int unsigned                   x_pos;
  int unsigned                   y_pos;
  logic signed [COEF_BITS-1:0]   b_coef [MAX_TAPS];
  logic signed [COEF_BITS-1:0]   a_coef [MAX_TAPS];
  filt_result_t                  expected_outputs [$];
  int                            errors;

  function new();
    tap_reg = TAP_CNT_BITS'(TAP_CNT_RESET);
    clear_histories();
    foreach (b_coef[i]) begin
      b_coef[i] = '0;
      a_coef[i] = '0;
    end
    errors = 0;
  endfunction

  function void clear_histories();
    foreach (x_hist[i]) begin
      x_hist[i] = '0;
      y_hist[i] = '0;
    end
    x_pos = 0;
    y_pos = 0;
  endfunction

  // A tap count write restarts the filter but keeps the coefficients.
  function void write_taps(logic [TAP_CNT_BITS-1:0] value);
    tap_reg = value;
    clear_histories();
  endfunction

  function int unsigned active_taps();
    if (int'(tap_reg) < 2) return 2;
    if (int'(tap_reg) > MAX_TAPS) return MAX_TAPS;
    return int'(tap_reg);
  endfunction

  // One filter step: store the sample, run both sums, round, clip, feed back.
  function filt_result_t filter_sample(logic signed [SAMPLE_BITS-1:0] smp);
    int unsigned  taps;
    int unsigned  pos;
    int unsigned  k;
    longint       acc;
    longint       y;
    longint       hi;
    longint       lo;
    filt_result_t res;
    taps = active_taps();
    hi = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    lo = -hi - 1;
    if (x_pos >= taps) x_pos = 0;
    if (y_pos >= taps - 1) y_pos = 0;
    x_hist[x_pos] = smp;
    x_pos++;
    if (x_pos >= taps) x_pos = 0;
    acc = 0;
    pos = x_pos;
    for (k = 0; k < taps; k++) begin
      pos = (pos > 0) ? pos - 1 : taps - 1;
      acc += longint'(b_coef[k]) * longint'(x_hist[pos]);
    end
    pos = y_pos;
    for (k = 1; k < taps; k++) begin
      pos = (pos > 0) ? pos - 1 : taps - 2;
      acc -= longint'(a_coef[k]) * longint'(y_hist[pos]);
    end
    // Round to nearest, ties toward plus infinity.
    acc += longint'(1) << (COEF_FRAC_BITS - 1);
    y = acc >>> COEF_FRAC_BITS;
    res.saturated = 1'b0;
    if (y > hi) begin
      y = hi;
      res.saturated = 1'b1;
    end else if (y < lo) begin
      y = lo;
      res.saturated = 1'b1;
    end
    res.sample_out = SAMPLE_BITS'(y);
    y_hist[y_pos] = res.sample_out;
    y_pos++;
    if (y_pos >= taps - 1) y_pos = 0;
    return res;
  endfunction

  function void accept_request(logic [REQ_BITS-1:0] req, logic [COEF_IDX_BITS-1:0] idx,
                               logic signed [COEF_BITS-1:0] value,
                               logic signed [SAMPLE_BITS-1:0] smp);
    case (req)
      REQ_FWD_COEF: b_coef[idx] = value;
      REQ_FBK_COEF: a_coef[idx] = value;
      REQ_SAMPLE:   expected_outputs.push_back(filter_sample(smp));
      default: ;
    endcase
  endfunction

  function void check_output(logic signed [SAMPLE_BITS-1:0] smp_out, logic sat);
    filt_result_t exp_res;
    if (expected_outputs.size() == 0) begin
      $error("unexpected output transaction: sample_out %0d saturated %0b", smp_out, sat);
      errors++;
      return;
    end
    exp_res = expected_outputs.pop_front();
    if (smp_out !== exp_res.sample_out) begin
      $error("sample_out mismatch: expected %0d, actual %0d", exp_res.sample_out, smp_out);
      errors++;
    end
    if (sat !== exp_res.saturated) begin
      $error("saturated mismatch: expected %0b, actual %0b", exp_res.saturated, sat);
      errors++;
    end
  endfunction

  function int pending();
    return expected_outputs.size();
  endfunction
endclass

module tb_top;

  // The request code that the block must ignore.
  localparam logic [REQ_BITS-1:0] REQ_UNUSED = 2'd3;

  // Fixed-point one in Q5.19 and the coefficient extremes.
  localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1 << COEF_FRAC_BITS);
  localparam logic signed [COEF_BITS-1:0] COEF_MAX = COEF_BITS'((1 << (COEF_BITS - 1)) - 1);
  localparam logic signed [COEF_BITS-1:0] COEF_MIN = COEF_BITS'(-(1 << (COEF_BITS - 1)));

  localparam int RANDOM_ITEMS = 1600;
  // Covers one sample at the full tap count, with margin, before a cfg write.
  localparam int DRAIN_CYCLES = 2 * MAX_TAPS + 8;
  // Watchdog limit, kept well above the length of the slowest run.
  localparam int LIMIT_CYCLES = 600000;

  typedef enum {RX_ALWAYS, RX_RANDOM, RX_BURSTY} rx_mode_t;
  typedef enum {SCALE_FINE, SCALE_UNIT, SCALE_FULL} coef_scale_t;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [TAP_CNT_BITS-1:0] cfg_wdata;

  iir_df1_in_if  in_if ();
  iir_df1_out_if out_if ();

  iir_direct_form_one_filter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  iir_output_checker sb;

  int unsigned cycles;
  int          burst_left;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  // Every output transaction is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      sb.check_output(out_if.sample_out, out_if.saturated);
    end
  end

  // Receiver back-pressure. The mode changes at random intervals so that
  // there are stretches with no stalls, scattered random stalls, and long
  // stalls that hold results in the output register and stall the block.
  initial begin
    rx_mode_t rx_mode;
    int       mode_left;
    int       run_left;
    bit       stalled;
    rx_mode   = RX_ALWAYS;
    mode_left = 0;
    run_left  = 0;
    stalled   = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(200, 800);
      end
      mode_left--;
      case (rx_mode)
        RX_ALWAYS: out_if.ready = 1'b1;
        RX_RANDOM: out_if.ready = ($urandom_range(0, 3) != 0);
        default: begin
          if (run_left == 0) begin
            stalled  = !stalled;
            run_left = stalled ? $urandom_range(1, 40) : $urandom_range(1, 12);
          end
          run_left--;
          out_if.ready = !stalled;
        end
      endcase
    end
  end

  // Drives one input transaction and waits for it to be accepted. The sender
  // works in bursts; between bursts valid may drop for a random gap.
  task automatic send_request(logic [REQ_BITS-1:0] req, logic [COEF_IDX_BITS-1:0] idx,
                              logic signed [COEF_BITS-1:0] value,
                              logic signed [SAMPLE_BITS-1:0] smp);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      @(negedge clk);
      if (gap > 0) begin
        in_if.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end else begin
      @(negedge clk);
    end
    in_if.req_type   = req;
    in_if.coef_index = idx;
    in_if.coef_value = value;
    in_if.sample_in  = smp;
    in_if.valid      = 1'b1;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.accept_request(req, idx, value, smp);
    burst_left--;
  endtask

  // Stops the sender and waits until every prediction has been matched and
  // any coefficient write still in flight has landed.
  task automatic wait_idle();
    @(negedge clk);
    in_if.valid = 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Only call this while the block is idle.
  task automatic set_tap_count(logic [TAP_CNT_BITS-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    sb.write_taps(value);
  endtask

  function automatic logic signed [COEF_BITS-1:0] random_coef(coef_scale_t scale);
    case (scale)
      SCALE_FINE: return COEF_BITS'(int'($urandom_range(0, 65535)) - 32768);
      SCALE_UNIT: return COEF_BITS'(int'($urandom_range(0, 1048575)) - COEF_ONE);
      default:    return COEF_BITS'($urandom());
    endcase
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    if ($urandom_range(0, 1) == 1) return SAMPLE_BITS'($urandom());
    return SAMPLE_BITS'(int'($urandom_range(0, 511)) - 256);
  endfunction

  initial begin
    logic [TAP_CNT_BITS-1:0] taps_plan [6];
    logic [TAP_CNT_BITS-1:0] taps_value;
    coef_scale_t             scale;
    int                      taps;
    int                      phase;
    int                      total_items;
    int                      phase_items;
    int                      phase_len;
    int                      pick;
    int                      k;

    sb = new();
    taps_plan = '{5'd2, 5'd16, 5'd0, 5'd1, 5'd31, 5'd17};
    burst_left = 0;

    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_if.valid      = 1'b0;
    in_if.req_type   = REQ_SAMPLE;
    in_if.coef_index = '0;
    in_if.coef_value = '0;
    in_if.sample_in  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part at the reset tap count of three.
    // With all coefficients cleared a full-scale input gives zero.
    send_request(REQ_SAMPLE, 0, 0, 16'sd32767);
    // Largest positive gain clips both ways.
    send_request(REQ_FWD_COEF, 0, COEF_MAX, 0);
    send_request(REQ_SAMPLE, 0, 0, 16'sd32767);
    send_request(REQ_SAMPLE, 0, 0, -16'sd32768);
    // Most negative gain on the most negative sample clips high.
    send_request(REQ_FWD_COEF, 0, COEF_MIN, 0);
    send_request(REQ_SAMPLE, 0, 0, -16'sd32768);
    // Unit gain with feedback; a[0] is stored but has no effect.
    send_request(REQ_FWD_COEF, 0, COEF_ONE, 0);
    send_request(REQ_FBK_COEF, 0, COEF_MAX, 0);
    send_request(REQ_FBK_COEF, 1, COEF_ONE / 2, 0);
    send_request(REQ_SAMPLE, 0, 0, 16'sd1000);
    send_request(REQ_SAMPLE, 0, 0, -16'sd1000);
    // Coefficients above the taps in use are stored but stay unused.
    send_request(REQ_FWD_COEF, 15, COEF_MIN, 0);
    send_request(REQ_FBK_COEF, 15, COEF_MAX, 0);
    // The unused request code must change nothing.
    send_request(REQ_UNUSED, 15, -24'sd1, -16'sd1);
    // Half gain and no feedback: exact ties round toward plus infinity.
    send_request(REQ_FWD_COEF, 0, COEF_ONE / 2, 0);
    send_request(REQ_FBK_COEF, 1, 0, 0);
    send_request(REQ_SAMPLE, 0, 0, 16'sd1);
    send_request(REQ_SAMPLE, 0, 0, -16'sd1);
    send_request(REQ_SAMPLE, 0, 0, 16'sd3);
    wait_idle();
    // Growing to the full length brings the stored index-15 words into use.
    set_tap_count(5'd16);
    send_request(REQ_SAMPLE, 0, 0, 16'sd32767);
    send_request(REQ_SAMPLE, 0, 0, -16'sd32768);
    send_request(REQ_SAMPLE, 0, 0, 16'sd0);

    // Random part: each phase picks a tap count, loads a full coefficient set
    // for it, then streams mostly samples with coefficient updates and noise.
    total_items = 0;
    phase = 0;
    while (total_items < RANDOM_ITEMS) begin
      wait_idle();
      taps_value = (phase < 6) ? taps_plan[phase] : TAP_CNT_BITS'($urandom_range(0, 31));
      set_tap_count(taps_value);
      taps = sb.active_taps();
      scale = coef_scale_t'($urandom_range(0, 2));
      for (k = 0; k < taps; k++) begin
        send_request(REQ_FWD_COEF, COEF_IDX_BITS'(k), random_coef(scale), 0);
      end
      for (k = 1; k < taps; k++) begin
        send_request(REQ_FBK_COEF, COEF_IDX_BITS'(k), random_coef(scale), 0);
      end
      if ($urandom_range(0, 1) == 1) begin
        send_request(REQ_FBK_COEF, 0, random_coef(SCALE_FULL), 0);
      end
      total_items += 2 * taps - 1;
      phase_len = $urandom_range(60, 140);
      phase_items = 0;
      while (phase_items < phase_len) begin
        pick = $urandom_range(0, 99);
        if (pick < 78) begin
          send_request(REQ_SAMPLE, COEF_IDX_BITS'($urandom()), COEF_BITS'($urandom()),
                       random_sample());
          phase_items++;
        end else if (pick < 88) begin
          send_request(REQ_FWD_COEF, COEF_IDX_BITS'($urandom()), random_coef(scale),
                       SAMPLE_BITS'($urandom()));
          phase_items++;
        end else if (pick < 95) begin
          send_request(REQ_FBK_COEF, COEF_IDX_BITS'($urandom()), random_coef(scale),
                       SAMPLE_BITS'($urandom()));
          phase_items++;
        end else begin
          // Ignored noise; not counted as stimulus.
          send_request(REQ_UNUSED, COEF_IDX_BITS'($urandom()), COEF_BITS'($urandom()),
                       SAMPLE_BITS'($urandom()));
        end
      end
      total_items += phase_items;
      phase++;
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
